/* src/gas_pkg.sv */
// Shared types, codes and reset constants for the gearshift actuation sequencer.
package gas_pkg;

    localparam int POSITION_BITS_DEF = 12;
    localparam int TIMER_BITS_DEF    = 24;

    localparam int TOL_BITS     = 12;
    localparam int TORQUE_BITS  = 11;
    localparam int NTORQUE_BITS = 10;
    localparam int GEAR_BITS    = 3;
    localparam int STATUS_BITS  = 4;
    localparam int CFG_IDX_BITS = 3;

    localparam int REST_POSITION_RST  = 2502;
    localparam int UP_STOP_RST        = 2290;
    localparam int DOWN_STOP_RST      = 2670;
    localparam int TOLERANCE_RST      = 20;
    localparam int TIMEOUT_RST        = 200000;
    localparam int UP_TORQUE_RST      = 400;
    localparam int DOWN_TORQUE_RST    = -400;
    localparam int NEUTRAL_TORQUE_RST = 400;

    localparam logic [GEAR_BITS-1:0] GEAR_NEUTRAL = 3'd0;
    localparam logic [GEAR_BITS-1:0] GEAR_FIRST   = 3'd1;
    localparam logic [GEAR_BITS-1:0] GEAR_SECOND  = 3'd2;
    localparam logic [GEAR_BITS-1:0] GEAR_TOP     = 3'd5;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_SAMPLE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_UP      = 2'd1,
        REQ_DOWN    = 2'd2,
        REQ_NEUTRAL = 2'd3
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_IDLE         = 4'd0,
        ST_STARTED      = 4'd1,
        ST_SHIFTING     = 4'd2,
        ST_DONE         = 4'd3,
        ST_TIMEOUT      = 4'd4,
        ST_READ_FAULT   = 4'd5,
        ST_INVALID      = 4'd6,
        ST_OUT_OF_RANGE = 4'd7,
        ST_NO_NEUTRAL   = 4'd8,
        ST_PRECHECK     = 4'd9,
        ST_BUSY         = 4'd10
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE           = 3'd0,
        CFG_UP_STOP        = 3'd1,
        CFG_DOWN_STOP      = 3'd2,
        CFG_TOLERANCE      = 3'd3,
        CFG_TIMEOUT        = 3'd4,
        CFG_UP_TORQUE      = 3'd5,
        CFG_DOWN_TORQUE    = 3'd6,
        CFG_NEUTRAL_TORQUE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GEAR_BITS-1:0]          gear;
        logic                          active;
        req_t                          req;
        logic signed [TORQUE_BITS-1:0] torque;
    } gas_ctrl_t;

    typedef struct packed {
        logic                          shifting;
        logic [GEAR_BITS-1:0]          gear;
        status_t                       status;
        logic signed [TORQUE_BITS-1:0] torque;
    } gas_result_t;

endpackage

/* src/gearshift_actuation_sequencer.sv */
// Top level of the gearshift actuation sequencer: handshakes, state and result registers.
//
// Shift actuation sequencer for a gearbox. Each input transaction is a tick, a shift
// request (carrying the pre-check encoder reading) or an encoder sample, selected by
// s_tuser, and each one yields exactly one result transaction holding the torque
// command in thousandths, a status code, the current gear and the shifting flag.
// A transaction is captured in an input register and processed when the result
// slot is empty or being emptied: the single-pass decision logic reads the gear,
// mode, active request, tick counter and torque registers, updates them and writes
// the result register. One transaction is taken every cycle while the output side
// keeps up; each result is offered from the result register, not combinationally.
// The result register and the input register form a two-deep pipeline, so a new
// transaction is still accepted while a result waits to be taken, provided the
// input register is empty. Configuration is written through the plain write port
// and should only change while no transaction is in flight.
module gearshift_actuation_sequencer #(
    parameter int POSITION_BITS = gas_pkg::POSITION_BITS_DEF,
    parameter int TIMER_BITS    = gas_pkg::TIMER_BITS_DEF,
    localparam int IN_W   = 2 + POSITION_BITS + 1,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = gas_pkg::TORQUE_BITS + gas_pkg::STATUS_BITS
                            + gas_pkg::GEAR_BITS + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8,
    localparam int CFG_MAX0 = (POSITION_BITS > TIMER_BITS) ? POSITION_BITS : TIMER_BITS,
    localparam int CFG_W    = (CFG_MAX0 > gas_pkg::TOL_BITS) ? CFG_MAX0 : gas_pkg::TOL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // request [1:0], position [POSITION_BITS+1:2], read_ok, zero fill
    input  logic [IN_TW-1:0]                 s_tdata,
    // operation
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // torque [10:0], status [14:11], gear [17:15], shifting [18], zero fill
    output logic [OUT_TW-1:0]                m_tdata,
    input  logic                             cfg_we,
    input  logic [gas_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data
);
    import gas_pkg::*;

    logic [POSITION_BITS-1:0]      rest_position, up_stop_position, down_stop_position;
    logic [TOL_BITS-1:0]           position_tolerance;
    logic [TIMER_BITS-1:0]         shift_timeout_ticks;
    logic signed [TORQUE_BITS-1:0] up_drive, down_drive;
    logic [NTORQUE_BITS-1:0]       neutral_drive;

    // Input register: one captured transaction awaiting processing.
    logic                     in_valid_reg;
    logic [1:0]               in_op_reg;
    logic [1:0]               in_req_reg;
    logic [POSITION_BITS-1:0] in_pos_reg;
    logic                     in_ok_reg;

    // Sequencer state.
    gas_ctrl_t             ctrl_reg, ctrl_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;

    // Result register.
    logic        out_valid_reg;
    gas_result_t out_result_reg, result_next;

    logic advance;
    logic step_en;

    // The pipeline moves whenever the result slot is empty or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    gas_cfg_regs #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS),
        .CFG_W         (CFG_W)
    ) u_cfg (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .rest_position       (rest_position),
        .up_stop_position    (up_stop_position),
        .down_stop_position  (down_stop_position),
        .position_tolerance  (position_tolerance),
        .shift_timeout_ticks (shift_timeout_ticks),
        .up_drive            (up_drive),
        .down_drive          (down_drive),
        .neutral_drive       (neutral_drive)
    );

    gas_step #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_step (
        .op                  (in_op_reg),
        .req                 (in_req_reg),
        .position            (in_pos_reg),
        .read_ok             (in_ok_reg),
        .ctrl                (ctrl_reg),
        .elapsed             (elapsed_reg),
        .rest_position       (rest_position),
        .up_stop_position    (up_stop_position),
        .down_stop_position  (down_stop_position),
        .position_tolerance  (position_tolerance),
        .shift_timeout_ticks (shift_timeout_ticks),
        .up_drive            (up_drive),
        .down_drive          (down_drive),
        .neutral_drive       (neutral_drive),
        .ctrl_next           (ctrl_next),
        .elapsed_next        (elapsed_next),
        .result              (result_next)
    );

    // Input capture; payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser;
            in_req_reg <= s_tdata[1:0];
            in_pos_reg <= s_tdata[POSITION_BITS+1:2];
            in_ok_reg  <= s_tdata[POSITION_BITS+2];
        end
    end

    // State is updated only when a transaction is actually processed, so a stalled
    // output never lets the same transaction act twice.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.gear   <= GEAR_NEUTRAL;
            ctrl_reg.active <= 1'b0;
            ctrl_reg.req    <= REQ_NONE;
            ctrl_reg.torque <= '0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                ctrl_reg    <= ctrl_next;
                elapsed_reg <= elapsed_next;
            end
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_result_reg);

`ifndef SYNTH
    // The input side only stalls when both the input and the result registers are full.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

    // With the actuation window closed the motor must not be driven.
    a_idle_no_torque: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_result_reg.shifting) |-> (out_result_reg.torque == '0))
        else $error("torque commanded outside the actuation window");

    // A started shift opens the window; a finished one closes it.
    a_status_window: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_result_reg.status == ST_STARTED)) |-> out_result_reg.shifting)
        else $error("shift started without opening the window");

    a_close_window: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_result_reg.status == ST_DONE
                      || out_result_reg.status == ST_TIMEOUT
                      || out_result_reg.status == ST_READ_FAULT))
        |-> !out_result_reg.shifting)
        else $error("window left open after the shift ended");

    // The gear register never leaves the range neutral to top gear.
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.gear <= GEAR_TOP)
        else $error("gear out of range");
`endif

endmodule

/* src/gas_cfg_regs.sv */
// Configuration register file of the gearshift actuation sequencer.
module gas_cfg_regs #(
    parameter int POSITION_BITS = gas_pkg::POSITION_BITS_DEF,
    parameter int TIMER_BITS    = gas_pkg::TIMER_BITS_DEF,
    parameter int CFG_W         = 24
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [gas_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                            cfg_data,
    output logic [POSITION_BITS-1:0]                    rest_position,
    output logic [POSITION_BITS-1:0]                    up_stop_position,
    output logic [POSITION_BITS-1:0]                    down_stop_position,
    output logic [gas_pkg::TOL_BITS-1:0]                position_tolerance,
    output logic [TIMER_BITS-1:0]                       shift_timeout_ticks,
    output logic signed [gas_pkg::TORQUE_BITS-1:0]      up_drive,
    output logic signed [gas_pkg::TORQUE_BITS-1:0]      down_drive,
    output logic [gas_pkg::NTORQUE_BITS-1:0]            neutral_drive
);
    import gas_pkg::*;

    logic [POSITION_BITS-1:0]      base_reg, up_stop_reg, down_stop_reg;
    logic [TOL_BITS-1:0]           tol_reg;
    logic [TIMER_BITS-1:0]         timeout_reg;
    logic signed [TORQUE_BITS-1:0] up_torque_reg, down_torque_reg;
    logic [NTORQUE_BITS-1:0]       neutral_torque_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg           <= POSITION_BITS'(REST_POSITION_RST);
            up_stop_reg        <= POSITION_BITS'(UP_STOP_RST);
            down_stop_reg      <= POSITION_BITS'(DOWN_STOP_RST);
            tol_reg            <= TOL_BITS'(TOLERANCE_RST);
            timeout_reg        <= TIMER_BITS'(TIMEOUT_RST);
            up_torque_reg      <= TORQUE_BITS'(UP_TORQUE_RST);
            down_torque_reg    <= TORQUE_BITS'(DOWN_TORQUE_RST);
            neutral_torque_reg <= NTORQUE_BITS'(NEUTRAL_TORQUE_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE:           base_reg           <= cfg_data[POSITION_BITS-1:0];
                CFG_UP_STOP:        up_stop_reg        <= cfg_data[POSITION_BITS-1:0];
                CFG_DOWN_STOP:      down_stop_reg      <= cfg_data[POSITION_BITS-1:0];
                CFG_TOLERANCE:      tol_reg            <= cfg_data[TOL_BITS-1:0];
                CFG_TIMEOUT:        timeout_reg        <= cfg_data[TIMER_BITS-1:0];
                CFG_UP_TORQUE:      up_torque_reg      <= $signed(cfg_data[TORQUE_BITS-1:0]);
                CFG_DOWN_TORQUE:    down_torque_reg    <= $signed(cfg_data[TORQUE_BITS-1:0]);
                CFG_NEUTRAL_TORQUE: neutral_torque_reg <= cfg_data[NTORQUE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign rest_position       = base_reg;
    assign up_stop_position    = up_stop_reg;
    assign down_stop_position  = down_stop_reg;
    assign position_tolerance  = tol_reg;
    assign shift_timeout_ticks = timeout_reg;
    assign up_drive            = up_torque_reg;
    assign down_drive          = down_torque_reg;
    assign neutral_drive       = neutral_torque_reg;

endmodule

/* src/gas_step.sv */
// Next-state and result logic for one transaction of the shift sequencer.
module gas_step #(
    parameter int POSITION_BITS = gas_pkg::POSITION_BITS_DEF,
    parameter int TIMER_BITS    = gas_pkg::TIMER_BITS_DEF
) (
    input  logic [1:0]                                  op,
    input  logic [1:0]                                  req,
    input  logic [POSITION_BITS-1:0]                    position,
    input  logic                                        read_ok,
    input  gas_pkg::gas_ctrl_t                          ctrl,
    input  logic [TIMER_BITS-1:0]                       elapsed,
    input  logic [POSITION_BITS-1:0]                    rest_position,
    input  logic [POSITION_BITS-1:0]                    up_stop_position,
    input  logic [POSITION_BITS-1:0]                    down_stop_position,
    input  logic [gas_pkg::TOL_BITS-1:0]                position_tolerance,
    input  logic [TIMER_BITS-1:0]                       shift_timeout_ticks,
    input  logic signed [gas_pkg::TORQUE_BITS-1:0]      up_drive,
    input  logic signed [gas_pkg::TORQUE_BITS-1:0]      down_drive,
    input  logic [gas_pkg::NTORQUE_BITS-1:0]            neutral_drive,
    output gas_pkg::gas_ctrl_t                          ctrl_next,
    output logic [TIMER_BITS-1:0]                       elapsed_next,
    output gas_pkg::gas_result_t                        result
);
    import gas_pkg::*;

    localparam int CMP_W = (POSITION_BITS > TOL_BITS) ? POSITION_BITS : TOL_BITS;

    function automatic logic near(input logic [POSITION_BITS-1:0] a,
                                  input logic [POSITION_BITS-1:0] b,
                                  input logic [TOL_BITS-1:0] tol);
        logic [POSITION_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return CMP_W'(d) <= CMP_W'(tol);
    endfunction

    function automatic logic [GEAR_BITS-1:0] gear_after(input req_t r,
                                                        input logic [GEAR_BITS-1:0] g);
        logic [GEAR_BITS-1:0] n;
        n = g;
        case (r)
            REQ_UP:
                if (g == GEAR_NEUTRAL) n = GEAR_SECOND;
                else if (g < GEAR_TOP) n = g + 3'd1;
            REQ_DOWN:
                if (g == GEAR_NEUTRAL) n = GEAR_FIRST;
                else if (g > GEAR_FIRST) n = g - 3'd1;
            REQ_NEUTRAL:
                n = GEAR_NEUTRAL;
            default:
                n = g;
        endcase
        return n;
    endfunction

    logic [TIMER_BITS-1:0]         elapsed_inc;
    logic [POSITION_BITS-1:0]      target;
    logic signed [TORQUE_BITS-1:0] neutral_torque;
    req_t                          req_in;
    status_t                       status;

    assign req_in      = req_t'(req);
    assign elapsed_inc = elapsed + TIMER_BITS'(1);

    always_comb
    begin
        case (ctrl.req)
            REQ_UP:   target = up_stop_position;
            REQ_DOWN: target = down_stop_position;
            default:  target = rest_position;
        endcase
    end

    // Neutral pushes towards base: sign from the pre-check position.
    always_comb
    begin
        if (near(position, rest_position, position_tolerance))
            neutral_torque = '0;
        else if (position > rest_position)
            neutral_torque = $signed({1'b0, neutral_drive});
        else
            neutral_torque = -$signed({1'b0, neutral_drive});
    end

    always_comb
    begin
        ctrl_next    = ctrl;
        elapsed_next = elapsed;
        status       = ctrl.active ? ST_SHIFTING : ST_IDLE;
        unique case (op)
            OP_TICK:
                if (ctrl.active)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= shift_timeout_ticks)
                    begin
                        ctrl_next.active = 1'b0;
                        ctrl_next.torque = '0;
                        status           = ST_TIMEOUT;
                    end
                end
            OP_REQUEST:
                if (ctrl.active)
                    status = ST_BUSY;
                else
                begin
                    if (req_in == REQ_NONE)
                        status = ST_INVALID;
                    else if (req_in == REQ_UP && ctrl.gear == GEAR_TOP)
                        status = ST_OUT_OF_RANGE;
                    else if (req_in == REQ_DOWN && ctrl.gear == GEAR_FIRST)
                        status = ST_OUT_OF_RANGE;
                    else if (req_in == REQ_NEUTRAL && ctrl.gear != GEAR_FIRST
                             && ctrl.gear != GEAR_SECOND)
                        status = ST_NO_NEUTRAL;
                    else if (!read_ok)
                        status = ST_PRECHECK;
                    else
                        status = ST_STARTED;

                    if (status != ST_STARTED)
                        ctrl_next.torque = '0;
                    else
                    begin
                        case (req_in)
                            REQ_UP:   ctrl_next.torque = up_drive;
                            REQ_DOWN: ctrl_next.torque = down_drive;
                            default:  ctrl_next.torque = neutral_torque;
                        endcase
                        ctrl_next.active = 1'b1;
                        ctrl_next.req    = req_in;
                        elapsed_next     = '0;
                    end
                end
            OP_SAMPLE:
                if (ctrl.active)
                begin
                    if (!read_ok)
                    begin
                        ctrl_next.active = 1'b0;
                        ctrl_next.torque = '0;
                        status           = ST_READ_FAULT;
                    end
                    else if (near(position, target, position_tolerance))
                    begin
                        ctrl_next.active = 1'b0;
                        ctrl_next.torque = '0;
                        ctrl_next.gear   = gear_after(ctrl.req, ctrl.gear);
                        status           = ST_DONE;
                    end
                end
            default:
                ;
        endcase
    end

    assign result.shifting = ctrl_next.active;
    assign result.gear     = ctrl_next.gear;
    assign result.status   = status;
    assign result.torque   = ctrl_next.torque;

endmodule

/* tb/sv/gas_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the gearshift actuation sequencer: watches both streams, predicts and compares.
module gas_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // request [1:0], position [13:2], read_ok [14], zero fill
    input  logic [15:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // torque [10:0], status [14:11], gear [17:15], shifting [18], zero fill
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output logic [15:0] status_seen
);
    import gas_pkg::*;

    // Shadow copy of the configuration registers.
    logic [11:0]        base_pos;
    logic [11:0]        up_stop;
    logic [11:0]        down_stop;
    logic [11:0]        tol;
    logic [23:0]        timeout_ticks;
    logic signed [10:0] up_tq;
    logic signed [10:0] down_tq;
    logic [9:0]         neutral_tq;

    // Predicted sequencer state.
    logic [2:0]         gear;
    bit                 shift_on;
    req_t               act_req;
    logic [23:0]        ticks;
    logic signed [10:0] torque;

    gas_result_t expected_results[$];

    task automatic report_mismatch(string msg);
        if (mismatches < 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit on_target(logic [11:0] p, logic [11:0] t);
        int d;
        d = (p > t) ? int'(p) - int'(t) : int'(t) - int'(p);
        return d <= int'(tol);
    endfunction

    function automatic gas_result_t step_sequencer(logic [1:0] op, logic [1:0] req,
                                                   logic [11:0] pos, logic ok);
        gas_result_t r;
        status_t     st;
        logic [11:0] target;
        st = shift_on ? ST_SHIFTING : ST_IDLE;
        case (op)
            OP_TICK:
            begin
                if (shift_on)
                begin
                    ticks = ticks + 24'd1;
                    if (ticks >= timeout_ticks)
                    begin
                        shift_on = 1'b0;
                        torque   = '0;
                        st       = ST_TIMEOUT;
                    end
                end
            end
            OP_REQUEST:
            begin
                if (shift_on)
                    st = ST_BUSY;
                else
                begin
                    if (req == REQ_NONE)
                        st = ST_INVALID;
                    else if (req == REQ_UP && gear == GEAR_TOP)
                        st = ST_OUT_OF_RANGE;
                    else if (req == REQ_DOWN && gear == GEAR_FIRST)
                        st = ST_OUT_OF_RANGE;
                    else if (req == REQ_NEUTRAL && gear != GEAR_FIRST && gear != GEAR_SECOND)
                        st = ST_NO_NEUTRAL;
                    else if (!ok)
                        st = ST_PRECHECK;
                    else
                        st = ST_STARTED;

                    if (st != ST_STARTED)
                        torque = '0;
                    else
                    begin
                        if (req == REQ_UP)
                            torque = up_tq;
                        else if (req == REQ_DOWN)
                            torque = down_tq;
                        else if (on_target(pos, base_pos))
                            torque = '0;
                        else if (pos > base_pos)
                            torque = $signed({1'b0, neutral_tq});
                        else
                            torque = -$signed({1'b0, neutral_tq});
                        shift_on = 1'b1;
                        act_req  = req_t'(req);
                        ticks    = '0;
                    end
                end
            end
            OP_SAMPLE:
            begin
                if (shift_on)
                begin
                    target = (act_req == REQ_UP)   ? up_stop :
                             (act_req == REQ_DOWN) ? down_stop : base_pos;
                    if (!ok)
                    begin
                        shift_on = 1'b0;
                        torque   = '0;
                        st       = ST_READ_FAULT;
                    end
                    else if (on_target(pos, target))
                    begin
                        shift_on = 1'b0;
                        torque   = '0;
                        st       = ST_DONE;
                        case (act_req)
                            REQ_UP:
                                gear = (gear == GEAR_NEUTRAL) ? GEAR_SECOND :
                                       (gear < GEAR_TOP) ? gear + 3'd1 : gear;
                            REQ_DOWN:
                                gear = (gear == GEAR_NEUTRAL) ? GEAR_FIRST :
                                       (gear > GEAR_FIRST) ? gear - 3'd1 : gear;
                            REQ_NEUTRAL:
                                gear = GEAR_NEUTRAL;
                            default:
                                gear = gear;
                        endcase
                    end
                end
            end
            default:
                st = st;
        endcase
        r.torque   = torque;
        r.status   = st;
        r.gear     = gear;
        r.shifting = shift_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gas_result_t got;
        gas_result_t want;
        if (!rst_n)
        begin
            base_pos      = 12'(REST_POSITION_RST);
            up_stop       = 12'(UP_STOP_RST);
            down_stop     = 12'(DOWN_STOP_RST);
            tol           = 12'(TOLERANCE_RST);
            timeout_ticks = 24'(TIMEOUT_RST);
            up_tq         = 11'(UP_TORQUE_RST);
            down_tq       = 11'(DOWN_TORQUE_RST);
            neutral_tq    = 10'(NEUTRAL_TORQUE_RST);
            gear          = GEAR_NEUTRAL;
            shift_on      = 1'b0;
            act_req       = REQ_NONE;
            ticks         = '0;
            torque        = '0;
            expected_results.delete();
            mismatches    = 0;
            outstanding   = 0;
            checked       = 0;
            status_seen   = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:           base_pos      = cfg_data[11:0];
                    CFG_UP_STOP:        up_stop       = cfg_data[11:0];
                    CFG_DOWN_STOP:      down_stop     = cfg_data[11:0];
                    CFG_TOLERANCE:      tol           = cfg_data[11:0];
                    CFG_TIMEOUT:        timeout_ticks = cfg_data[23:0];
                    CFG_UP_TORQUE:      up_tq         = cfg_data[10:0];
                    CFG_DOWN_TORQUE:    down_tq       = cfg_data[10:0];
                    CFG_NEUTRAL_TORQUE: neutral_tq    = cfg_data[9:0];
                    default:            tol           = tol;
                endcase
            end

            if (s_tvalid && s_tready)
                expected_results.push_back(step_sequencer(s_tuser, s_tdata[1:0],
                                                          s_tdata[13:2], s_tdata[14]));

            if (m_tvalid && m_tready)
            begin
                got = gas_result_t'(m_tdata[18:0]);
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %h arrived with nothing expected",
                                              m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    status_seen[want.status] = 1'b1;
                    if (got.torque !== want.torque)
                        report_mismatch($sformatf("torque %0d, expected %0d",
                                                  got.torque, want.torque));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.gear !== want.gear)
                        report_mismatch($sformatf("gear %0d, expected %0d",
                                                  got.gear, want.gear));
                    if (got.shifting !== want.shifting)
                        report_mismatch($sformatf("shifting %0b, expected %0b",
                                                  got.shifting, want.shifting));
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

/* tb/sv/tb_gearshift_actuation_sequencer.sv */
`timescale 1ns / 100ps
// Top-level testbench for the gearshift actuation sequencer: clock, reset, stimulus and verdict.
module tb_gearshift_actuation_sequencer;
    import gas_pkg::*;

    localparam int IN_TW  = 16;
    localparam int OUT_TW = 24;
    localparam int CFG_W  = 24;

    // The operation field has one spare code, which the block must treat as a no-op.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int PHASE_ITEMS = 300;
    localparam int LONG_HOLD   = 120;
    // Cycles without any transaction on either stream before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_TW-1:0] m_tdata;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_index = CFG_BASE;
    logic [CFG_W-1:0]  cfg_data  = '0;

    int          mismatches;
    int          outstanding;
    int          checked;
    logic [15:0] status_seen;

    // Idle percentages for each side and a pending long hold-off for the receiver.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;
    int sent        = 0;
    int settings_used = 1;
    int stall_cycles  = 0;
    // Copy of what has been written to the registers, used to aim encoder samples.
    int cfg_shadow[8];

    always #2 clk = ~clk;

    gearshift_actuation_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gas_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .status_seen (status_seen)
    );

    // Receiver: takes results at random according to the current idle rate, except
    // during a long hold-off, which it counts down itself so that the block backs up
    // while the sender keeps offering transactions.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a correct block never goes this long without moving a transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one transaction and returns in the time step of the edge that accepted it.
    task automatic send_item(logic [1:0] op, logic [1:0] req, int pos, logic ok);
        s_tuser  <= op;
        s_tdata  <= {1'b0, ok, 12'(pos), req};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Random gaps on the sending side; each idle cycle is a time step of its own.
    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops sending until every expected result has been taken, then lets the block
    // sit idle so that nothing is left in its pipeline.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_we     <= 1'b1;
        cfg_index  <= idx;
        cfg_data   <= CFG_W'(val);
        cfg_shadow[idx] = val;
        @(posedge clk);
    endtask

    task automatic load_setting(int base, int up_stop, int down_stop, int tol, int tmo,
                                int up_tq, int down_tq, int neutral_tq);
        write_reg(CFG_BASE, base);
        write_reg(CFG_UP_STOP, up_stop);
        write_reg(CFG_DOWN_STOP, down_stop);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_UP_TORQUE, up_tq);
        write_reg(CFG_DOWN_TORQUE, down_tq);
        write_reg(CFG_NEUTRAL_TORQUE, neutral_tq);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Stop positions anywhere, a tight tolerance and a short timeout so that every
    // way of ending a shift turns up regularly.
    task automatic load_random_setting(int tmo);
        load_setting($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(40), tmo,
                     int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                     $urandom_range(1000));
    endtask

    function automatic int stop_for(logic [1:0] req);
        if (req == REQ_UP)
            return cfg_shadow[CFG_UP_STOP];
        if (req == REQ_DOWN)
            return cfg_shadow[CFG_DOWN_STOP];
        return cfg_shadow[CFG_BASE];
    endfunction

    // An encoder reading close to the given stop: sometimes exact, otherwise within a
    // few counts either side of the tolerance band.
    function automatic int reading_near(int stop);
        int band;
        int p;
        band = (cfg_shadow[CFG_TOLERANCE] > 60) ? 63 : cfg_shadow[CFG_TOLERANCE] + 3;
        if ($urandom_range(99) < 30)
            p = stop;
        else
            p = stop + int'($urandom_range(2 * band)) - band;
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        return p;
    endfunction

    // Mostly well-formed shifts (a request followed by ticks and encoder samples aimed
    // at its stop position), with some noise and some sequences cut short or broken.
    task automatic shift_traffic(int n_items);
        int          done_items;
        int          pick;
        logic [1:0]  req;
        int          pos;
        done_items = 0;
        while (done_items < n_items)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_item(2'($urandom), 2'($urandom), $urandom_range(4095), 1'($urandom));
                sender_gap();
                done_items++;
            end
            else
            begin
                req = ($urandom_range(19) == 0) ? REQ_NONE : 2'($urandom_range(1, 3));
                if (req == REQ_NEUTRAL && $urandom_range(99) < 30)
                    pos = reading_near(cfg_shadow[CFG_BASE]);
                else
                    pos = $urandom_range(4095);
                send_item(OP_REQUEST, req, pos, $urandom_range(9) != 0);
                sender_gap();
                done_items++;
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        send_item(OP_SAMPLE, 2'($urandom), reading_near(stop_for(req)),
                                  $urandom_range(19) != 0);
                    else if (pick < 65)
                        send_item(OP_SAMPLE, 2'($urandom), $urandom_range(4095), 1'b1);
                    else if (pick < 88)
                        send_item(OP_TICK, 2'($urandom), $urandom_range(4095), 1'($urandom));
                    else if (pick < 95)
                        send_item(OP_REQUEST, 2'($urandom), $urandom_range(4095),
                                  1'($urandom));
                    else
                        send_item(OP_SPARE, 2'($urandom), $urandom_range(4095), 1'($urandom));
                    sender_gap();
                    done_items++;
                end
            end
        end
    endtask

    initial
    begin
        cfg_shadow[CFG_BASE]           = REST_POSITION_RST;
        cfg_shadow[CFG_UP_STOP]        = UP_STOP_RST;
        cfg_shadow[CFG_DOWN_STOP]      = DOWN_STOP_RST;
        cfg_shadow[CFG_TOLERANCE]      = TOLERANCE_RST;
        cfg_shadow[CFG_TIMEOUT]        = TIMEOUT_RST;
        cfg_shadow[CFG_UP_TORQUE]      = UP_TORQUE_RST;
        cfg_shadow[CFG_DOWN_TORQUE]    = DOWN_TORQUE_RST;
        cfg_shadow[CFG_NEUTRAL_TORQUE] = NEUTRAL_TORQUE_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the reset configuration, starting in neutral: idle
        // traffic, every refusal, a busy request, the edges of the tolerance band and
        // a neutral shift with the torque sign taken from each side of the base.
        send_item(OP_TICK, REQ_NONE, 0, 1'b0);
        send_item(OP_SAMPLE, REQ_NONE, 4095, 1'b1);
        send_item(OP_SPARE, REQ_UP, 0, 1'b1);
        send_item(OP_REQUEST, REQ_NONE, REST_POSITION_RST, 1'b1);
        send_item(OP_REQUEST, REQ_NEUTRAL, REST_POSITION_RST, 1'b1);
        send_item(OP_REQUEST, REQ_UP, UP_STOP_RST, 1'b0);
        send_item(OP_REQUEST, REQ_UP, 4095, 1'b1);
        send_item(OP_REQUEST, REQ_DOWN, 0, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, 0, 1'b1);
        send_item(OP_TICK, REQ_NEUTRAL, 4095, 1'b1);
        send_item(OP_SPARE, REQ_NEUTRAL, 4095, 1'b0);
        send_item(OP_SAMPLE, REQ_NONE, UP_STOP_RST + TOLERANCE_RST, 1'b1);
        send_item(OP_REQUEST, REQ_DOWN, REST_POSITION_RST, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, DOWN_STOP_RST, 1'b0);
        send_item(OP_REQUEST, REQ_NEUTRAL, 4095, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, REST_POSITION_RST - TOLERANCE_RST, 1'b1);
        send_item(OP_REQUEST, REQ_DOWN, REST_POSITION_RST, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, DOWN_STOP_RST + TOLERANCE_RST + 1, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, DOWN_STOP_RST, 1'b1);
        send_item(OP_REQUEST, REQ_DOWN, REST_POSITION_RST, 1'b1);
        send_item(OP_REQUEST, REQ_NEUTRAL, REST_POSITION_RST, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, REST_POSITION_RST + TOLERANCE_RST, 1'b1);
        send_item(OP_REQUEST, REQ_DOWN, 0, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, DOWN_STOP_RST, 1'b1);
        send_item(OP_REQUEST, REQ_NEUTRAL, 0, 1'b1);
        send_item(OP_SAMPLE, REQ_NONE, REST_POSITION_RST, 1'b1);
        wait_all_results();

        // Random phases. The first two starve the output side, the next two the input
        // side, the last two run flat out. Each phase has its own register setting,
        // and halfway through the sender waits for every result to come back.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase < 2)
            begin
                tx_idle_pct = 17;
                rx_idle_pct = 71;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 71;
                rx_idle_pct = 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case (phase)
                0: load_setting(REST_POSITION_RST, UP_STOP_RST, DOWN_STOP_RST, TOLERANCE_RST,
                                6, 1000, -1000, 1000);
                1: load_setting(0, 4095, 0, 0, 1, -1000, 1000, 0);
                // A tolerance this wide makes every sample an arrival.
                2: load_setting(4095, 0, 4095, 4095, 16777215, 0, 0, 1000);
                // A zero timeout must behave as a timeout of one tick.
                4: load_random_setting(0);
                default: load_random_setting($urandom_range(2, 12));
            endcase

            // With the receiver held off the block fills up and must stall its input.
            if (phase == 4)
                rx_hold = LONG_HOLD;

            shift_traffic(PHASE_ITEMS / 2);
            wait_all_results();
            shift_traffic(PHASE_ITEMS / 2);
            wait_all_results();
        end

        repeat (8) @(posedge clk);

        $display("Sent %0d transactions under %0d register settings; %0d results checked.",
                 sent, settings_used, checked);
        $display("Status codes seen, one bit per code from bit 0: %b", status_seen[10:0]);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
